@@ hdl/bld_pkg.sv @@
// Package with the shared constants, codes and item types of the ballistic launch direction unit.
package bld_pkg;

  localparam int unsigned HEIGHT_OFFSET = 30;
  localparam int unsigned TANGENT_LIMIT = 2;

  localparam logic [15:0] GRAVITY_RESET = 16'd980;
  localparam logic [15:0] SPEED_RESET   = 16'd1500;

  typedef enum logic [1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_SPEED   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOT   = 2'd1,
    ST_ZERO_DIST = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] offset_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] launch_tangent;
    status_e            status;
  } out_t;

endpackage

@@ hdl/ballistic_launch_direction.sv @@
// Pipelined launch direction solver: tangent of elevation and unit aim vector per item.
// Depth: 137 register stages, from the input register through the output register.
// Throughput: one item per cycle while the output is not stalled; square roots and divisions resolve one bit per stage.
// Each stage holds its item while the next is full and stalled; empty stages are refilled.
// Reset empties the pipeline and loads gravity 980 and speed 1500 into the registers.
module ballistic_launch_direction (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bld_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bld_pkg::out_t    out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int K_MUL1 = 1;
  localparam int K_MUL2 = 2;
  localparam int K_MUL3 = 3;
  localparam int K_RZ   = 4;
  localparam int K_ADD  = 5;
  localparam int K_CMP  = 6;
  localparam int K_SQ1  = 7;
  localparam int K_DEN  = K_SQ1 + 41;
  localparam int K_MAG  = K_DEN + 1;
  localparam int K_TNUM = K_MAG + 1;
  localparam int K_TOVF = K_TNUM + 1;
  localparam int K_TDIV = K_TOVF + 1;
  localparam int K_TSAT = K_TDIV + 16;
  localparam int K_W    = K_TSAT + 1;
  localparam int K_PM   = K_W + 1;
  localparam int K_PMS  = K_PM + 1;
  localparam int K_SQ2  = K_PMS + 1;
  localparam int K_DNUM = K_SQ2 + 47;
  localparam int K_DDIV = K_DNUM + 1;
  localparam int K_OUT  = K_DDIV + 16;
  localparam int NST    = K_OUT;

  typedef struct packed {
    logic [23:0] ax;
    logic [23:0] ay;
    logic [23:0] az;
    logic        xneg;
    logic        yneg;
    logic        zneg;
    logic [47:0] d2;
    logic [31:0] s2;
    logic [31:0] gg;
    logic [47:0] gs2;
    logic [55:0] neg_lo;
    logic [55:0] neg_hi;
    logic [47:0] rz_lo;
    logic [47:0] rz_hi;
    logic [81:0] pos;
    logic [81:0] neg;
    logic [81:0] rz;
    logic        nr;
    logic        zd;
    logic [81:0] e_rem;
    logic [40:0] r;
    logic [47:0] d_rem;
    logic [23:0] dr;
    logic [39:0] den;
    logic [41:0] mag;
    logic        tneg;
    logic [55:0] tn;
    logic [15:0] tq;
    logic        tovf;
    logic [15:0] at;
    logic [30:0] w;
    logic [54:0] pm_lo;
    logic [54:0] pm_hi;
    logic [93:0] p_rem;
    logic [46:0] nxy;
    logic [46:0] m_rem;
    logic [23:0] mz;
    logic [59:0] xr;
    logic [59:0] yr;
    logic [39:0] zr;
    logic [15:0] xq;
    logic [15:0] yq;
    logic [15:0] zq;
    bld_pkg::out_t res;
  } pipe_t;

  typedef struct packed {
    logic [95:0] rem;
    logic [47:0] root;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [15:0] q;
  } dv_t;

  function automatic sq_t sq_step(logic [95:0] rem, logic [47:0] root, int bi);
    sq_t         o;
    logic [95:0] trial;
    trial = (96'(root) << (bi + 1)) + (96'd1 << (2 * bi));
    o.rem = rem;
    o.root = root;
    if (rem >= trial) begin
      o.rem = rem - trial;
      o.root = root | (48'd1 << bi);
    end
    return o;
  endfunction

  function automatic dv_t div_step(logic [63:0] rem, logic [63:0] dsor, logic [15:0] q, int bi);
    dv_t         o;
    logic [63:0] sh;
    sh = dsor << bi;
    o.rem = rem;
    o.q = q;
    if (rem >= sh) begin
      o.rem = rem - sh;
      o.q = q | (16'd1 << bi);
    end
    return o;
  endfunction

  function automatic pipe_t front(bld_pkg::in_t d);
    pipe_t              n;
    logic signed [24:0] zs;
    n = '0;
    zs = 25'(d.offset_z) + 25'(bld_pkg::HEIGHT_OFFSET * 256);
    n.xneg = d.offset_x[23];
    n.yneg = d.offset_y[23];
    n.zneg = zs[24];
    n.ax = d.offset_x[23] ? (24'd0 - d.offset_x) : d.offset_x;
    n.ay = d.offset_y[23] ? (24'd0 - d.offset_y) : d.offset_y;
    n.az = zs[24] ? 24'(25'd0 - zs) : zs[23:0];
    return n;
  endfunction

  function automatic pipe_t stage_fn(int k, pipe_t p, logic [15:0] g, logic [15:0] s);
    pipe_t       n;
    sq_t         sq;
    dv_t         dv;
    logic [41:0] big;
    logic [41:0] sum;
    logic [42:0] lim;
    int          j;
    n = p;
    j = 0;
    if (k == K_MUL1) begin
      n.d2 = p.ax * p.ax + p.ay * p.ay;
      n.s2 = s * s;
      n.gg = g * g;
    end else if (k == K_MUL2) begin
      n.pos = (82'(p.s2) * 82'(p.s2)) << 16;
      n.gs2 = 48'(g) * 48'(p.s2);
      n.neg_lo = 56'(p.gg) * 56'(p.d2[23:0]);
      n.neg_hi = 56'(p.gg) * 56'(p.d2[47:24]);
    end else if (k == K_MUL3) begin
      n.rz_lo = 48'(p.gs2[23:0]) * 48'(p.az);
      n.rz_hi = 48'(p.gs2[47:24]) * 48'(p.az);
      n.neg = (82'(p.neg_hi) << 24) + 82'(p.neg_lo);
    end else if (k == K_RZ) begin
      n.rz = ((82'(p.rz_hi) << 24) + 82'(p.rz_lo)) << 9;
    end else if (k == K_ADD) begin
      if (p.zneg) begin
        n.pos = p.pos + p.rz;
      end else begin
        n.neg = p.neg + p.rz;
      end
    end else if (k == K_CMP) begin
      n.nr = p.neg > p.pos;
      n.zd = p.d2 == 48'd0;
      n.e_rem = p.pos - p.neg;
      n.r = '0;
      n.d_rem = p.d2;
      n.dr = '0;
    end else if (k >= K_SQ1 && k < K_DEN) begin
      j = k - K_SQ1;
      sq = sq_step(96'(p.e_rem), 48'(p.r), 40 - j);
      n.e_rem = sq.rem[81:0];
      n.r = sq.root[40:0];
      if (j < 24) begin
        sq = sq_step(96'(p.d_rem), 48'(p.dr), 23 - j);
        n.d_rem = sq.rem[47:0];
        n.dr = sq.root[23:0];
      end
    end else if (k == K_DEN) begin
      n.den = 40'(g) * 40'(p.dr);
    end else if (k == K_MAG) begin
      big = 42'(p.s2) << 8;
      sum = big + 42'(p.r);
      lim = 43'(p.den) * 43'(bld_pkg::TANGENT_LIMIT);
      if (43'(sum) <= lim) begin
        n.mag = sum;
        n.tneg = 1'b0;
      end else if (big >= 42'(p.r)) begin
        n.mag = big - 42'(p.r);
        n.tneg = 1'b0;
      end else begin
        n.mag = 42'(p.r) - big;
        n.tneg = 1'b1;
      end
    end else if (k == K_TNUM) begin
      n.tn = (56'(p.mag) << 13) + 56'(p.den);
      n.tq = '0;
    end else if (k == K_TOVF) begin
      n.tovf = 64'(p.tn) >= (64'(p.den) << 17);
    end else if (k >= K_TDIV && k < K_TSAT) begin
      dv = div_step(64'(p.tn), 64'(p.den) << 1, p.tq, 15 - (k - K_TDIV));
      n.tn = dv.rem[55:0];
      n.tq = dv.q;
    end else if (k == K_TSAT) begin
      if (p.tneg) begin
        n.at = (p.tovf || p.tq > 16'd32768) ? 16'd32768 : p.tq;
      end else begin
        n.at = (p.tovf || p.tq > 16'd32767) ? 16'd32767 : p.tq;
      end
    end else if (k == K_W) begin
      n.w = 31'd16777216 + 31'(p.at) * 31'(p.at);
    end else if (k == K_PM) begin
      n.pm_lo = 55'(p.d2[23:0]) * 55'(p.w);
      n.pm_hi = 55'(p.d2[47:24]) * 55'(p.w);
      n.m_rem = 47'(p.w) << 16;
      n.nxy = '0;
      n.mz = '0;
    end else if (k == K_PMS) begin
      n.p_rem = ((94'(p.pm_hi) << 24) + 94'(p.pm_lo)) << 16;
    end else if (k >= K_SQ2 && k < K_DNUM) begin
      j = k - K_SQ2;
      sq = sq_step(96'(p.p_rem), 48'(p.nxy), 46 - j);
      n.p_rem = sq.rem[93:0];
      n.nxy = sq.root[46:0];
      if (j < 24) begin
        sq = sq_step(96'(p.m_rem), 48'(p.mz), 23 - j);
        n.m_rem = sq.rem[46:0];
        n.mz = sq.root[23:0];
      end
    end else if (k == K_DNUM) begin
      n.xr = (60'(p.ax) << 35) + 60'(p.nxy);
      n.yr = (60'(p.ay) << 35) + 60'(p.nxy);
      n.zr = (40'(p.at) << 23) + 40'(p.mz);
      n.xq = '0;
      n.yq = '0;
      n.zq = '0;
    end else if (k >= K_DDIV && k < K_OUT) begin
      j = 15 - (k - K_DDIV);
      dv = div_step(64'(p.xr), 64'(p.nxy) << 1, p.xq, j);
      n.xr = dv.rem[59:0];
      n.xq = dv.q;
      dv = div_step(64'(p.yr), 64'(p.nxy) << 1, p.yq, j);
      n.yr = dv.rem[59:0];
      n.yq = dv.q;
      dv = div_step(64'(p.zr), 64'(p.mz) << 1, p.zq, j);
      n.zr = dv.rem[39:0];
      n.zq = dv.q;
    end else if (k == K_OUT) begin
      n.res = '0;
      if (p.zd) begin
        n.res.status = bld_pkg::ST_ZERO_DIST;
      end else if (p.nr) begin
        n.res.status = bld_pkg::ST_NO_ROOT;
      end else begin
        n.res.status = bld_pkg::ST_OK;
        n.res.dir_x = p.xneg ? (16'd0 - p.xq) : p.xq;
        n.res.dir_y = p.yneg ? (16'd0 - p.yq) : p.yq;
        n.res.dir_z = p.tneg ? (16'd0 - p.zq) : p.zq;
        n.res.launch_tangent = p.tneg ? (16'd0 - p.at) : p.at;
      end
    end
    return n;
  endfunction

  logic [15:0] gravity_q;
  logic [15:0] speed_q;
  logic [15:0] g_eff;
  logic [15:0] s_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= bld_pkg::GRAVITY_RESET;
      speed_q <= bld_pkg::SPEED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bld_pkg::CFG_GRAVITY: gravity_q <= cfg_data_i;
        bld_pkg::CFG_SPEED:   speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign g_eff = (gravity_q == 16'd0) ? 16'd1 : gravity_q;
  assign s_eff = (speed_q == 16'd0) ? 16'd1 : speed_q;

  pipe_t        pipe_q [NST+1];
  pipe_t        pipe_d [NST+1];
  logic [NST:0] vld_q;
  logic [NST+1:0] rdy;

  assign rdy[NST+1] = !out_stall_i;
  assign pipe_d[0] = front(in_data_i);

  for (genvar k = 0; k <= NST; k++) begin : g_stage
    assign rdy[k] = !vld_q[k] || rdy[k+1];
    if (k > 0) begin : g_fn
      assign pipe_d[k] = stage_fn(k, pipe_q[k-1], g_eff, s_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NST; k++) begin
      if (rdy[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign in_stall_o = !rdy[0];
  assign out_valid_o = vld_q[NST];
  assign out_data_o = pipe_q[NST].res;

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the pipeline has no waiting item.");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != bld_pkg::ST_OK) |->
    (out_data_o.dir_x == 16'sd0 && out_data_o.dir_y == 16'sd0 &&
     out_data_o.dir_z == 16'sd0 && out_data_o.launch_tangent == 16'sd0))
    else $error("Nonzero direction on a flagged item.");

  a_tan_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == bld_pkg::ST_OK) |->
    (out_data_o.launch_tangent[15] == out_data_o.dir_z[15] &&
     (out_data_o.launch_tangent == 16'sd0) == (out_data_o.dir_z == 16'sd0)))
    else $error("Vertical component disagrees with the tangent sign.");

endmodule

@@ sim/tb_ballistic_launch_direction.sv @@
// Self-checking testbench for the ballistic launch direction solver.
`timescale 1ns / 100ps

module tb_ballistic_launch_direction;

  localparam int          LATENCY    = 140;
  localparam int          STALL_MAX  = 5000;
  localparam int          RAND_ITEMS = 250;
  localparam logic [1:0]  CFG_SPARE2 = 2'd2;
  localparam logic [1:0]  CFG_SPARE3 = 2'd3;

  typedef struct {
    bld_pkg::in_t  stim;
    bit            typed;
    bld_pkg::out_t want;
  } aim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  bld_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  bld_pkg::out_t out_data_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [15:0]   cfg_data_i;

  logic          row_typed;
  bld_pkg::out_t row_want;

  logic [15:0]   gravity_q;
  logic [15:0]   speed_q;
  bld_pkg::out_t pending_aims[$];
  bit            failed;
  int            quiet_cycles;
  int            sender_idle_pct;
  int            receiver_idle_pct;
  int            hold_request;
  int            hold_served;
  int            hold_left;
  aim_row_t      aim_rows[$];

  ballistic_launch_direction dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] acc;
    logic [127:0] cand;
    acc = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = acc | (128'd1 << b);
      if (cand * cand <= n) acc = cand;
    end
    return acc;
  endfunction

  function automatic logic [127:0] div_half_up(logic [127:0] num, logic [127:0] den);
    return (num * 2 + den) / (den * 2);
  endfunction

  function automatic logic [15:0] apply_sign(bit neg, logic [127:0] mag);
    logic [15:0] m;
    m = mag[15:0];
    return neg ? -m : m;
  endfunction

  function automatic bld_pkg::out_t aim_solution(bld_pkg::in_t v, logic [15:0] grav_reg,
                                                 logic [15:0] spd_reg);
    bld_pkg::out_t o;
    longint        px, py, pz;
    logic [127:0]  ax, ay, az, g, s2, d2, pos, neg, rz, r, dr, den, big, mag, q, at, w, mz, nxy;
    bit            tneg;
    o = '0;
    o.status = bld_pkg::ST_OK;
    px = v.offset_x;
    py = v.offset_y;
    pz = longint'(v.offset_z) + longint'(bld_pkg::HEIGHT_OFFSET) * 256;
    ax = 128'(px < 0 ? -px : px);
    ay = 128'(py < 0 ? -py : py);
    az = 128'(pz < 0 ? -pz : pz);
    g = 128'(grav_reg == 16'd0 ? 16'd1 : grav_reg);
    s2 = 128'(spd_reg == 16'd0 ? 16'd1 : spd_reg);
    s2 = s2 * s2;
    d2 = ax * ax + ay * ay;
    if (d2 == 0) begin
      o.status = bld_pkg::ST_ZERO_DIST;
      return o;
    end
    pos = (s2 * s2) << 16;
    neg = g * g * d2;
    rz = 2 * g * s2 * 256 * az;
    if (pz < 0) pos = pos + rz;
    else neg = neg + rz;
    if (neg > pos) begin
      o.status = bld_pkg::ST_NO_ROOT;
      return o;
    end
    r = root_floor(pos - neg);
    dr = root_floor(d2);
    den = g * dr;
    big = 256 * s2;
    tneg = 0;
    if (big + r <= bld_pkg::TANGENT_LIMIT * den) mag = big + r;
    else if (big >= r) mag = big - r;
    else begin
      mag = r - big;
      tneg = 1;
    end
    q = div_half_up(mag * 4096, den);
    if (tneg) at = q > 32768 ? 32768 : q;
    else at = q > 32767 ? 32767 : q;
    if (at == 0) tneg = 0;
    w = (128'd1 << 24) + at * at;
    mz = root_floor(w << 16);
    nxy = root_floor((d2 * w) << 16);
    o.dir_x = apply_sign(px < 0, div_half_up(ax << 34, nxy));
    o.dir_y = apply_sign(py < 0, div_half_up(ay << 34, nxy));
    o.dir_z = apply_sign(tneg, div_half_up(at << 22, mz));
    o.launch_tangent = apply_sign(tneg, at);
    return o;
  endfunction

  always @(posedge clk_i) begin
    bld_pkg::out_t want;
    bit            moved;
    moved = 0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1;
        if (cfg_index_i == bld_pkg::CFG_GRAVITY) gravity_q = cfg_data_i;
        else if (cfg_index_i == bld_pkg::CFG_SPEED) speed_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1;
        pending_aims.push_back(row_typed ? row_want
                                         : aim_solution(in_data_i, gravity_q, speed_q));
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1;
        if (pending_aims.size() == 0) begin
          failed = 1;
          $display("%0t: unexpected item x=%0d y=%0d z=%0d t=%0d st=%0d", $time,
                   out_data_o.dir_x, out_data_o.dir_y, out_data_o.dir_z,
                   out_data_o.launch_tangent, out_data_o.status);
        end else begin
          want = pending_aims.pop_front();
          if (out_data_o.dir_x !== want.dir_x || out_data_o.dir_y !== want.dir_y ||
              out_data_o.dir_z !== want.dir_z ||
              out_data_o.launch_tangent !== want.launch_tangent ||
              out_data_o.status !== want.status) begin
            failed = 1;
            $display("%0t: expected x=%0d y=%0d z=%0d t=%0d st=%0d", $time, want.dir_x,
                     want.dir_y, want.dir_z, want.launch_tangent, want.status);
            $display("%0t: actual   x=%0d y=%0d z=%0d t=%0d st=%0d", $time,
                     out_data_o.dir_x, out_data_o.dir_y, out_data_o.dir_z,
                     out_data_o.launch_tangent, out_data_o.status);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb_ballistic_launch_direction failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < receiver_idle_pct;
    end
  end

  task automatic send_aim(bld_pkg::in_t v, bit typed, bld_pkg::out_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= v;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_aims.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] random_offset();
    logic signed [23:0] v;
    v = 24'($urandom);
    return v >>> $urandom_range(23);
  endfunction

  function automatic aim_row_t make_row(int x, int y, int z, bit typed,
                                        bld_pkg::status_e st);
    aim_row_t r;
    r.stim.offset_x = 24'(x);
    r.stim.offset_y = 24'(y);
    r.stim.offset_z = 24'(z);
    r.typed = typed;
    r.want = '0;
    r.want.status = st;
    return r;
  endfunction

  initial begin
    logic [15:0]   grav_set[7];
    logic [15:0]   spd_set[7];
    bld_pkg::out_t none;
    bld_pkg::in_t  v;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bld_pkg::CFG_GRAVITY;
    cfg_data_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    none = '0;
    gravity_q = bld_pkg::GRAVITY_RESET;
    speed_q = bld_pkg::SPEED_RESET;
    failed = 0;
    quiet_cycles = 0;
    hold_request = 0;
    hold_served = 0;
    hold_left = 0;
    sender_idle_pct = 9;
    receiver_idle_pct = 88;
    grav_set = '{16'd980, 16'd65535, 16'd1, 16'd0, 16'd65535, 16'd1, 16'd0};
    spd_set = '{16'd1500, 16'd65535, 16'd1, 16'd0, 16'd1, 16'd65535, 16'd0};

    aim_rows.push_back(make_row(0, 0, 0, 1, bld_pkg::ST_ZERO_DIST));
    aim_rows.push_back(make_row(0, 0, 8388607, 1, bld_pkg::ST_ZERO_DIST));
    aim_rows.push_back(make_row(0, 0, -8388608, 1, bld_pkg::ST_ZERO_DIST));
    aim_rows.push_back(make_row(8388607, 0, 0, 1, bld_pkg::ST_NO_ROOT));
    aim_rows.push_back(make_row(-8388608, -8388608, -8388608, 1, bld_pkg::ST_NO_ROOT));
    aim_rows.push_back(make_row(0, 8388607, 8388607, 1, bld_pkg::ST_NO_ROOT));
    aim_rows.push_back(make_row(25600, 0, 0, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(0, -25600, -7680, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(1, 0, 0, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(-1, -1, -8388608, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(25600, 25600, 8388607, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(500000, 0, -8388608, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(-300000, 200000, 0, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(4000, -4000, 100000, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(580000, 1, -7680, 0, bld_pkg::ST_OK));
    aim_rows.push_back(make_row(-5592405, 5592405, -5592406, 0, bld_pkg::ST_OK));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (aim_rows[i]) send_aim(aim_rows[i].stim, aim_rows[i].typed, aim_rows[i].want);
    drain_pipe();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 3) begin
        sender_idle_pct = 9;
        receiver_idle_pct = 88;
      end else if (ph < 5) begin
        sender_idle_pct = 88;
        receiver_idle_pct = 9;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (ph == 6) begin
        grav_set[ph] = 16'($urandom_range(65535));
        spd_set[ph] = 16'($urandom_range(65535));
        write_reg(CFG_SPARE2, 16'($urandom));
      end
      write_reg(bld_pkg::CFG_GRAVITY, grav_set[ph]);
      write_reg(bld_pkg::CFG_SPEED, spd_set[ph]);
      if (ph == 3) write_reg(CFG_SPARE3, 16'($urandom));
      if (ph == 5) hold_request++;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        v.offset_x = random_offset();
        v.offset_y = random_offset();
        v.offset_z = random_offset();
        if ($urandom_range(19) == 0) begin
          v.offset_x = '0;
          v.offset_y = '0;
        end
        send_aim(v, 0, none);
      end
      drain_pipe();
    end

    if (!failed && pending_aims.size() == 0) begin
      $display("tb_ballistic_launch_direction passed");
    end else begin
      $display("tb_ballistic_launch_direction failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bld_pkg.sv
hdl/ballistic_launch_direction.sv
sim/tb_ballistic_launch_direction.sv
